@@ design/c8fp_pkg.sv @@
// shared types, codes and crc helpers for the crc8 frame parser
package c8fp_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_MAX = 3'd5;

	localparam logic [7:0] SYNC_FIRST_RST = 8'hA5;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h5A;
	localparam logic [7:0] END_MARKER_RST = 8'hEE;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;
	localparam logic [7:0] COMMAND_MIN_RST = 8'h01;
	localparam logic [7:0] COMMAND_MAX_RST = 8'h04;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] KIND_COMMAND = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] ERR_TIMEOUT = 2'd0;
	localparam logic [1:0] ERR_BAD_LENGTH = 2'd1;
	localparam logic [1:0] ERR_CRC = 2'd2;
	localparam logic [1:0] ERR_END_MARKER = 2'd3;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] MIN_LENGTH = 8'd2;
	localparam int IDLE_W = 17;
	localparam int CRC_STEPS = 4;

	typedef logic [7:0] byte_t;

	// one msb-first crc-8 shift
	function automatic byte_t crc8_bit(input byte_t c);
		byte_t r;
		r = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		return r;
	endfunction

	// two shifts, one pass of the shared crc unit
	function automatic byte_t crc8_two(input byte_t c);
		byte_t r;
		r = crc8_bit(crc8_bit(c));
		return r;
	endfunction

endpackage

@@ design/crc8_frame_parser.sv @@
// sync, length and crc-8 frame parser with error counters
//
// words enter on the request channel (req_valid/req_stall): operation 0
// carries a received byte in rx_data, operation 1 is a millisecond tick.
// results leave on the response channel (rsp_valid/rsp_stall): a command
// word and its payload words for a good frame with its command in the
// configured range, or a single error event. every result carries the
// four 32-bit error counters after the update. a sync, length or end
// byte and a tick are taken without the crc unit; a command or payload
// body byte is accepted and then runs four passes of the shared crc
// unit at two bits per pass. after a frame's end byte the command word
// is loaded when the output register is free, and each payload word
// takes a registered body memory read and then a load of the output.
// req_stall is high while the sequencer works on a word.
// reset returns to the sync hunt, clears the counters and idle time and
// loads the register defaults; the body memory is not cleared.
// a stalled response holds in the output register and the sequencer waits
// on it, so requests stall in turn.
module crc8_frame_parser #(
	parameter int MAX_BODY = 34
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [c8fp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [c8fp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic req_valid,
	output logic req_stall,
	input  logic operation,
	input  logic [7:0] rx_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic [1:0] kind,
	output logic [7:0] value,
	output logic [5:0] payload_length,
	output logic [1:0] error_code,
	output logic last,
	output logic [31:0] timeout_total,
	output logic [31:0] bad_length_total,
	output logic [31:0] crc_fail_total,
	output logic [31:0] end_error_total
);

	localparam int IDX_W = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
	localparam logic [7:0] MAX_LEN = 8'(MAX_BODY);

	typedef enum logic [2:0] {
		PH_SYNC0 = 3'd0,
		PH_SYNC1 = 3'd1,
		PH_LEN = 3'd2,
		PH_BODY = 3'd3,
		PH_END = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CRC,
		ST_EVENT,
		ST_CMD,
		ST_READ,
		ST_EMIT
	} state_t;

	logic [7:0] sync_first_q, sync_second_q, end_marker_q, cmd_min_q, cmd_max_q;
	logic [15:0] timeout_ticks_q;

	state_t state_q;
	logic [2:0] phase_q;
	logic [5:0] frame_len_q;
	logic [5:0] body_index_q;
	logic [5:0] emit_idx_q;
	logic [1:0] crc_step_q;
	logic [1:0] err_code_q;
	logic [7:0] crc_q, crc_byte_q, cmd_q;
	logic [c8fp_pkg::IDLE_W-1:0] idle_q, idle_next;
	logic [31:0] timeout_cnt_q, bad_len_cnt_q, crc_cnt_q, end_cnt_q;

	logic rsp_valid_q, last_q;
	logic [1:0] kind_q, code_out_q;
	logic [7:0] value_q;
	logic [5:0] plen_out_q;
	logic [31:0] timeout_out_q, bad_len_out_q, crc_out_q, end_out_q;

	logic [7:0] body_mem [MAX_BODY];
	logic [7:0] mem_rd_q;

	logic req_acc, slot_free, body_wr;
	logic [5:0] body_index_nxt, plen;

	assign req_acc = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign idle_next = (idle_q == '1) ? idle_q : idle_q + 1'b1;
	assign body_index_nxt = body_index_q + 6'd1;
	assign plen = frame_len_q - 6'd2;
	assign body_wr = req_acc && (operation == c8fp_pkg::OP_BYTE) && (phase_q == PH_BODY);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q <= c8fp_pkg::SYNC_FIRST_RST;
			sync_second_q <= c8fp_pkg::SYNC_SECOND_RST;
			end_marker_q <= c8fp_pkg::END_MARKER_RST;
			timeout_ticks_q <= c8fp_pkg::TIMEOUT_TICKS_RST;
			cmd_min_q <= c8fp_pkg::COMMAND_MIN_RST;
			cmd_max_q <= c8fp_pkg::COMMAND_MAX_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				c8fp_pkg::REG_SYNC_FIRST: sync_first_q <= cfg_data[7:0];
				c8fp_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_data[7:0];
				c8fp_pkg::REG_END_MARKER: end_marker_q <= cfg_data[7:0];
				c8fp_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				c8fp_pkg::REG_COMMAND_MIN: cmd_min_q <= cfg_data[7:0];
				c8fp_pkg::REG_COMMAND_MAX: cmd_max_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// frame body memory
	always_ff @(posedge clk) begin
		if (body_wr) begin
			body_mem[body_index_q[IDX_W-1:0]] <= rx_data;
		end
		mem_rd_q <= body_mem[emit_idx_q[IDX_W-1:0]];
	end

	// sequencer, parser state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_SYNC0;
			frame_len_q <= '0;
			body_index_q <= '0;
			emit_idx_q <= '0;
			crc_step_q <= '0;
			err_code_q <= c8fp_pkg::ERR_TIMEOUT;
			crc_q <= '0;
			crc_byte_q <= '0;
			cmd_q <= '0;
			idle_q <= '0;
			timeout_cnt_q <= '0;
			bad_len_cnt_q <= '0;
			crc_cnt_q <= '0;
			end_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
			kind_q <= c8fp_pkg::KIND_COMMAND;
			value_q <= '0;
			plen_out_q <= '0;
			code_out_q <= c8fp_pkg::ERR_TIMEOUT;
			last_q <= 1'b0;
			timeout_out_q <= '0;
			bad_len_out_q <= '0;
			crc_out_q <= '0;
			end_out_q <= '0;
		end else begin
			if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc && operation == c8fp_pkg::OP_TICK) begin
						idle_q <= idle_next;
						if (phase_q != PH_SYNC0 && idle_next > {1'b0, timeout_ticks_q}) begin
							phase_q <= PH_SYNC0;
							timeout_cnt_q <= timeout_cnt_q + 32'd1;
							err_code_q <= c8fp_pkg::ERR_TIMEOUT;
							state_q <= ST_EVENT;
						end
					end else if (req_acc) begin
						idle_q <= '0;
						case (phase_q)
							PH_SYNC0: begin
								if (rx_data == sync_first_q) begin
									phase_q <= PH_SYNC1;
								end
							end
							PH_SYNC1: begin
								if (rx_data == sync_second_q) begin
									phase_q <= PH_LEN;
								end else if (rx_data != sync_first_q) begin
									phase_q <= PH_SYNC0;
								end
							end
							PH_LEN: begin
								if (rx_data < c8fp_pkg::MIN_LENGTH || rx_data > MAX_LEN) begin
									bad_len_cnt_q <= bad_len_cnt_q + 32'd1;
									err_code_q <= c8fp_pkg::ERR_BAD_LENGTH;
									phase_q <= PH_SYNC0;
									state_q <= ST_EVENT;
								end else begin
									frame_len_q <= rx_data[5:0];
									body_index_q <= '0;
									crc_q <= '0;
									phase_q <= PH_BODY;
								end
							end
							PH_BODY: begin
								if (body_index_q == '0) begin
									cmd_q <= rx_data;
								end
								if (body_index_nxt < frame_len_q) begin
									crc_q <= crc_q ^ rx_data;
									crc_step_q <= 2'(c8fp_pkg::CRC_STEPS - 1);
									state_q <= ST_CRC;
								end else begin
									crc_byte_q <= rx_data;
									phase_q <= PH_END;
								end
								body_index_q <= body_index_nxt;
							end
							PH_END: begin
								phase_q <= PH_SYNC0;
								emit_idx_q <= 6'd1;
								if (rx_data != end_marker_q) begin
									end_cnt_q <= end_cnt_q + 32'd1;
									err_code_q <= c8fp_pkg::ERR_END_MARKER;
									state_q <= ST_EVENT;
								end else if (crc_byte_q != crc_q) begin
									crc_cnt_q <= crc_cnt_q + 32'd1;
									err_code_q <= c8fp_pkg::ERR_CRC;
									state_q <= ST_EVENT;
								end else if (cmd_q >= cmd_min_q && cmd_q <= cmd_max_q) begin
									state_q <= ST_CMD;
								end
							end
							default: phase_q <= PH_SYNC0;
						endcase
					end
				end
				ST_CRC: begin
					crc_q <= c8fp_pkg::crc8_two(crc_q);
					crc_step_q <= crc_step_q - 2'd1;
					if (crc_step_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EVENT: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						kind_q <= c8fp_pkg::KIND_ERROR;
						value_q <= '0;
						plen_out_q <= '0;
						code_out_q <= err_code_q;
						last_q <= 1'b1;
						timeout_out_q <= timeout_cnt_q;
						bad_len_out_q <= bad_len_cnt_q;
						crc_out_q <= crc_cnt_q;
						end_out_q <= end_cnt_q;
						state_q <= ST_IDLE;
					end
				end
				ST_CMD: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						kind_q <= c8fp_pkg::KIND_COMMAND;
						value_q <= cmd_q;
						plen_out_q <= plen;
						code_out_q <= c8fp_pkg::ERR_TIMEOUT;
						last_q <= (plen == '0);
						timeout_out_q <= timeout_cnt_q;
						bad_len_out_q <= bad_len_cnt_q;
						crc_out_q <= crc_cnt_q;
						end_out_q <= end_cnt_q;
						state_q <= (plen == '0) ? ST_IDLE : ST_READ;
					end
				end
				ST_READ: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						kind_q <= c8fp_pkg::KIND_PAYLOAD;
						value_q <= mem_rd_q;
						plen_out_q <= plen;
						code_out_q <= c8fp_pkg::ERR_TIMEOUT;
						last_q <= (emit_idx_q == plen);
						if (emit_idx_q == plen) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 6'd1;
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign kind = kind_q;
	assign value = value_q;
	assign payload_length = plen_out_q;
	assign error_code = code_out_q;
	assign last = last_q;
	assign timeout_total = timeout_out_q;
	assign bad_length_total = bad_len_out_q;
	assign crc_fail_total = crc_out_q;
	assign end_error_total = end_out_q;

`ifndef SYNTHESIS
	a_timeout_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_acc && operation == c8fp_pkg::OP_TICK) |=> $stable(timeout_cnt_q))
		else $error("timeout counter moved without a tick");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && kind_q == c8fp_pkg::KIND_ERROR |-> last_q && value_q == '0)
		else $error("error event not a single last word");

	a_body_length_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> frame_len_q >= 6'd2 && {2'b00, frame_len_q} <= MAX_LEN)
		else $error("body phase with illegal frame length");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> emit_idx_q >= 6'd1 && emit_idx_q <= plen)
		else $error("payload index out of range");
`endif

endmodule
